// ----- src/cobs_frame_encoder_assert.svh -----
// Assertion macros shared by the encoder checker.
`ifndef COBS_FRAME_ENCODER_ASSERT_SVH
`define COBS_FRAME_ENCODER_ASSERT_SVH

// Clocked property with active-low reset disable.
`define CFE_PROP(clk_s, rstn_s, prop) @(posedge clk_s) disable iff (!rstn_s) prop

// Named assertion on clk / rst_n that reports through $error.
`define CFE_ASSERT(label, prop, msg) \
  label: assert property (`CFE_PROP(clk, rst_n, prop)) else $error(msg);

`endif

// ----- src/cfe_pkg.sv -----
// Shared types and constants for the COBS frame encoder.
package cfe_pkg;

  localparam int unsigned STORE_DEPTH = 254;
  localparam logic [7:0] STORE_LIMIT = 8'(STORE_DEPTH);
  localparam logic [7:0] MAX_RUN = 8'd254;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CODE  = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_DELIM = 2'd3;

  localparam logic [7:0] DELIM_BYTE = 8'h00;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       frame_last;
    logic       rejected;
  } out_t;

endpackage

// ----- src/cfe_front.sv -----
// Front end: accepts transactions, runs the framing control and the run store.
module cfe_front
  import cfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic q_room,
  output logic s1_push,
  output out_t s1_data
);

  logic [7:0] run_store [0:STORE_DEPTH-1];
  logic [7:0] mem_q;

  logic [7:0] run_count_r, run_count_nxt;
  logic [7:0] drain_index_r, drain_index_nxt;
  logic [1:0] drain_phase_r, drain_phase_nxt;
  logic       close_after_r, close_after_nxt;
  logic       after_split_r, after_split_nxt;

  logic       s1_valid_r;
  out_t       s1_res_r;
  logic       s1_use_mem_r;

  logic       accept;
  logic       wr_en;
  logic       rd_en;
  logic [7:0] count_inc;
  logic [7:0] index_inc;
  logic [1:0] finish_phase;
  out_t       res_nxt;

  assign in_ready = !s1_valid_r || q_room;
  assign accept   = in_valid && in_ready;
  assign s1_push  = s1_valid_r && q_room;

  assign count_inc    = run_count_r + 8'd1;
  assign index_inc    = drain_index_r + 8'd1;
  assign finish_phase = close_after_r ? PH_DELIM : PH_IDLE;

  always_comb begin
    run_count_nxt   = run_count_r;
    drain_index_nxt = drain_index_r;
    drain_phase_nxt = drain_phase_r;
    close_after_nxt = close_after_r;
    after_split_nxt = after_split_r;
    res_nxt         = '0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    unique case (in_data.cmd)
      CMD_TICK: begin
        unique case (drain_phase_r)
          PH_CODE: begin
            res_nxt.out_valid = 1'b1;
            res_nxt.out_byte  = count_inc;
            if (run_count_r == 8'd0) begin
              run_count_nxt   = 8'd0;
              drain_index_nxt = 8'd0;
              drain_phase_nxt = finish_phase;
            end else begin
              drain_phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            res_nxt.out_valid = 1'b1;
            rd_en             = 1'b1;
            drain_index_nxt   = index_inc;
            if (index_inc >= run_count_r) begin
              run_count_nxt   = 8'd0;
              drain_index_nxt = 8'd0;
              drain_phase_nxt = finish_phase;
            end
          end
          PH_DELIM: begin
            res_nxt.out_valid  = 1'b1;
            res_nxt.out_byte   = DELIM_BYTE;
            res_nxt.frame_last = 1'b1;
            drain_phase_nxt    = PH_IDLE;
            close_after_nxt    = 1'b0;
          end
          default: begin
          end
        endcase
      end
      CMD_DATA, CMD_END: begin
        if (drain_phase_r != PH_IDLE) begin
          res_nxt.rejected = 1'b1;
        end else if (in_data.cmd == CMD_DATA) begin
          if (in_data.data_byte == 8'd0) begin
            after_split_nxt = 1'b0;
            close_after_nxt = 1'b0;
            drain_index_nxt = 8'd0;
            drain_phase_nxt = PH_CODE;
          end else begin
            if (run_count_r < STORE_LIMIT) begin
              wr_en         = 1'b1;
              run_count_nxt = count_inc;
            end
            if (run_count_nxt >= MAX_RUN || run_count_nxt >= STORE_LIMIT) begin
              after_split_nxt = 1'b1;
              close_after_nxt = 1'b0;
              drain_index_nxt = 8'd0;
              drain_phase_nxt = PH_CODE;
            end else begin
              after_split_nxt = 1'b0;
            end
          end
        end else begin
          // packet end: delimiter only if it ends right on a full run, else code byte first
          close_after_nxt = 1'b1;
          drain_index_nxt = 8'd0;
          if (after_split_r && run_count_r == 8'd0) begin
            drain_phase_nxt = PH_DELIM;
          end else begin
            drain_phase_nxt = PH_CODE;
          end
          after_split_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      run_store[run_count_r] <= in_data.data_byte;
    end
    if (accept && rd_en) begin
      mem_q <= run_store[drain_index_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_count_r   <= 8'd0;
      drain_index_r <= 8'd0;
      drain_phase_r <= PH_IDLE;
      close_after_r <= 1'b0;
      after_split_r <= 1'b0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        run_count_r   <= run_count_nxt;
        drain_index_r <= drain_index_nxt;
        drain_phase_r <= drain_phase_nxt;
        close_after_r <= close_after_nxt;
        after_split_r <= after_split_nxt;
        s1_valid_r    <= 1'b1;
      end else if (s1_push) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r     <= res_nxt;
      s1_use_mem_r <= rd_en;
    end
  end

  always_comb begin
    s1_data = s1_res_r;
    if (s1_use_mem_r) begin
      s1_data.out_byte = mem_q;
    end
  end

endmodule

// ----- src/cfe_queue.sv -----
// Back end: two-entry result queue driving the output channel.
module cfe_queue
  import cfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  out_t push_data,
  output logic room,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  out_t       entry_r [0:1];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign room      = count_r != 2'd2;
  assign out_valid = count_r != 2'd0;
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    priority if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

// ----- src/cobs_frame_encoder.sv -----
// COBS frame encoder top level: front end control plus result queue.
//
//   channel | direction | payload | handshake
//   in_     | input     | in_t    | in_valid / in_ready
//   out_    | output    | out_t   | out_valid / out_ready
//
// One transaction per cycle sustained while out_ready stays high; every input transaction yields one result.
// A result passes the front stage register (with the run store read), then the queue.
// Reset is synchronous; the run store has no reset and needs no clearing pass.
// out_ready low fills the two-entry queue; in_ready then drops until room returns.
module cobs_frame_encoder
  import cfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic q_room;
  logic s1_push;
  out_t s1_data;

  cfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_room   (q_room),
    .s1_push  (s1_push),
    .s1_data  (s1_data)
  );

  cfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_push),
    .push_data (s1_data),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/cfe_checker.sv -----
// Port-level checker for the COBS frame encoder, bound to the top level.
`include "cobs_frame_encoder_assert.svh"

module cfe_checker
  import cfe_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `CFE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `CFE_ASSERT(a_rej_no_byte, out_valid && out_data.rejected |-> !out_data.out_valid, "rejected transaction carries a byte")
  `CFE_ASSERT(a_delim_zero, out_valid && out_data.frame_last |-> out_data.out_valid && out_data.out_byte == DELIM_BYTE, "bad delimiter")
  `CFE_ASSERT(a_idle_zero, out_valid && !out_data.out_valid |-> out_data.out_byte == 8'd0 && !out_data.frame_last, "empty result not zero")

endmodule

bind cobs_frame_encoder cfe_checker u_cfe_checker (.*);
